FILE: hdl/plsi_pkg.sv
// Package for the piecewise-linear set-point interpolator.
// Holds the calibration source constants, row build and field helpers, and the sequencer states.
// No dependencies.
package plsi_pkg;

  localparam int DIST_W            = 16;
  localparam int VAL_W             = 16;
  localparam int ROW_W             = 64;
  localparam int RATIO_BITS        = 16;
  localparam int NUM_COLS          = 3;
  localparam int SOURCE_ROWS       = 5;
  localparam int DECIMAL_SCALE     = 10000;
  localparam int DEF_TABLE_ROWS    = 5;
  localparam int DEF_FRACTION_BITS = 6;

  // Calibration points in ten-thousandths: distance, one, two, three.
  localparam longint CAL_SRC [SOURCE_ROWS][4] = '{
    '{  593400, 500000,  750000,  -519000 },
    '{ 1074769, 300000, 1300000,  -895000 },
    '{ 1551600, 223000, 1750000, -1045000 },
    '{ 1727100, 212000, 2053000, -1047000 },
    '{ 2005800, 205000, 2500000, -1065000 }
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_ACC,
    S_DONE
  } plsi_state_t;

  // Scale by 2^frac, truncate toward zero.
  function automatic longint to_code(longint tenk, int frac);
    longint mag;
    longint q;
    mag = (tenk < 0) ? -tenk : tenk;
    q   = (mag <<< frac) / DECIMAL_SCALE;
    return (tenk < 0) ? -q : q;
  endfunction

  function automatic longint clamp_s16(longint v);
    longint r;
    r = v;
    if (v > 32767) r = 32767;
    if (v < -32768) r = -32768;
    return r;
  endfunction

  // One ROM row: [15:0] breakpoint, then three signed set-point columns.
  function automatic logic [ROW_W-1:0] cal_row(int r, int frac);
    int                 s;
    longint             d;
    longint             v;
    logic [ROW_W-1:0]   row;
    s   = (r < SOURCE_ROWS) ? r : SOURCE_ROWS - 1;
    row = '0;
    d   = to_code(CAL_SRC[s][0], frac);
    if (d > 65535) d = 65535;
    if (d < 0) d = 0;
    row[DIST_W-1:0] = d[DIST_W-1:0];
    for (int c = 0; c < NUM_COLS; c++) begin
      v = clamp_s16(to_code(CAL_SRC[s][c+1], frac));
      row[DIST_W + VAL_W*c +: VAL_W] = v[VAL_W-1:0];
    end
    return row;
  endfunction

  function automatic logic [DIST_W-1:0] row_dist(logic [ROW_W-1:0] row);
    return row[DIST_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] row_val(logic [ROW_W-1:0] row, logic [1:0] col);
    logic signed [VAL_W-1:0] v;
    case (col)
      2'd0:    v = row[DIST_W +: VAL_W];
      2'd1:    v = row[DIST_W + VAL_W +: VAL_W];
      2'd2:    v = row[DIST_W + 2*VAL_W +: VAL_W];
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(logic signed [VAL_W+2:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > (VAL_W+3)'(32767)) r = 16'sh7fff;
    else if (v < -(VAL_W+3)'(32768)) r = 16'sh8000;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

endpackage

FILE: hdl/plsi_rom.sv
// Calibration row memory for the set-point interpolator.
// Contents are built at elaboration from the package table; the read is registered.
// Depends on plsi_pkg.
module plsi_rom
  import plsi_pkg::*;
#(
  parameter int TABLE_ROWS    = DEF_TABLE_ROWS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  localparam int AW           = $clog2(TABLE_ROWS)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    addr,
  output logic [ROW_W-1:0] rd_data
);

  logic [ROW_W-1:0] mem [TABLE_ROWS];

  for (genvar r = 0; r < TABLE_ROWS; r++) begin : g_row
    localparam logic [ROW_W-1:0] ROW_C = cal_row(r, FRACTION_BITS);
    assign mem[r] = ROW_C;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

FILE: hdl/plsi_div.sv
// Restoring divider producing a RATIO_BITS fraction: floor((num << RATIO_BITS) / den).
// Requires num < den; one quotient bit per cycle.
// Depends on plsi_pkg.
module plsi_div
  import plsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIST_W-1:0]     num,
  input  logic [DIST_W-1:0]     den,
  output logic                  done,
  output logic [RATIO_BITS-1:0] quot
);

  localparam int CW = $clog2(RATIO_BITS + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DIST_W:0]   rem;
  logic [DIST_W-1:0] den_q;
  logic [DIST_W:0]   shifted;
  logic              ge;

  assign shifted = {rem[DIST_W-1:0], 1'b0};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_q <= den;
      quot  <= '0;
      cnt   <= CW'(RATIO_BITS);
    end else if (busy) begin
      rem  <= ge ? (shifted - {1'b0, den_q}) : shifted;
      quot <= {quot[RATIO_BITS-2:0], ge};
      cnt  <= cnt - CW'(1);
    end
  end

endmodule

FILE: hdl/piecewise_linear_setpoint_interp.sv
// Top level of the piecewise-linear set-point interpolator: sequencer, multiplier, output register.
// Depends on plsi_pkg, plsi_rom, plsi_div.
//
//   channel | signals                                         | dir
//   request | in_valid, in_stall, distance                    | in
//   result  | out_valid, out_stall, distance_echo, in_range,  | out
//           | value_one, value_two, value_three               |
//
// One request at a time. The row scan reads and then checks each ROM row (address, then compare),
// then the divider runs, then the three columns pass in turn through one multiplier, each with a
// multiply and an accumulate state, before the result is loaded. Requests out of range or on a
// breakpoint skip the divider and the multiplier.
// Reset clears the sequencer and the output valid; the ROM needs no clearing.
// A stalled result sits in the output register while the next request is already being worked.
module piecewise_linear_setpoint_interp
  import plsi_pkg::*;
#(
  parameter int TABLE_ROWS    = DEF_TABLE_ROWS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [DIST_W-1:0]       distance,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DIST_W-1:0]       distance_echo,
  output logic                    in_range,
  output logic signed [VAL_W-1:0] value_one,
  output logic signed [VAL_W-1:0] value_two,
  output logic signed [VAL_W-1:0] value_three
);

  localparam int AW = $clog2(TABLE_ROWS);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ROWS - 1);
  localparam int PW = 2 * (VAL_W + 1);

  plsi_state_t state, state_next;

  logic [DIST_W-1:0]           meas_dist;
  logic [AW-1:0]               idx;
  logic [1:0]                  col;
  logic [ROW_W-1:0]            row_a;
  logic [ROW_W-1:0]            row_b;
  logic [ROW_W-1:0]            rd_row;
  logic [RATIO_BITS-1:0]       ratio;
  logic signed [PW-1:0]        prod;
  logic signed [VAL_W-1:0]     vals [NUM_COLS];
  logic                        res_range;

  logic                        rom_rd;
  logic                        div_start;
  logic                        div_done;
  logic [RATIO_BITS-1:0]       div_quot;
  logic                        out_load;

  logic [DIST_W-1:0]           rd_d;
  logic                        hit;
  logic                        on_point;
  logic                        is_last;
  logic                        is_first;
  logic signed [VAL_W:0]       diff;
  logic signed [VAL_W:0]       ratio_s;
  logic signed [VAL_W+2:0]     acc;

  assign rd_d     = row_dist(rd_row);
  assign hit      = rd_d >= meas_dist;
  assign on_point = (rd_d == meas_dist) || (rd_d <= row_dist(row_a));
  assign is_last  = idx == LAST_IDX;
  assign is_first = idx == '0;
  assign diff     = (VAL_W+1)'(row_val(row_b, col)) - (VAL_W+1)'(row_val(row_a, col));
  assign ratio_s  = $signed({1'b0, ratio});
  // floor of prod / 2^16 is the upper slice of the product
  assign acc      = (VAL_W+3)'(row_val(row_a, col))
                  + (VAL_W+3)'($signed(prod[PW-1:RATIO_BITS]));

  plsi_rom #(
    .TABLE_ROWS    (TABLE_ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rom_rd),
    .addr    (idx),
    .rd_data (rd_row)
  );

  plsi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (meas_dist - row_dist(row_a)),
    .den   (rd_d - row_dist(row_a)),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_READ;
      S_READ:  state_next = S_CHECK;
      S_CHECK: begin
        if (is_first) begin
          state_next = hit ? S_DONE : S_READ;
        end else if (hit) begin
          state_next = on_point ? S_DONE : S_DIV;
        end else begin
          state_next = is_last ? S_DONE : S_READ;
        end
      end
      S_DIV:   if (div_done) state_next = S_MUL;
      S_MUL:   state_next = S_ACC;
      S_ACC:   state_next = (col == 2'd2) ? S_DONE : S_MUL;
      S_DONE:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state != S_IDLE;
    rom_rd    = state == S_READ;
    div_start = (state == S_CHECK) && !is_first && hit && !on_point;
    out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        meas_dist <= distance;
        idx       <= '0;
      end
      S_CHECK: begin
        if (is_first && !hit) begin
          row_a <= rd_row;
          idx   <= idx + AW'(1);
        end else if (!is_first && hit) begin
          row_b     <= rd_row;
          res_range <= 1'b1;
          for (int c = 0; c < NUM_COLS; c++) begin
            vals[c] <= row_val(rd_row, 2'(c));
          end
        end else if (!is_first && !is_last) begin
          row_a <= rd_row;
          idx   <= idx + AW'(1);
        end else begin
          // at or below the first breakpoint or beyond the last one
          res_range <= 1'b0;
          for (int c = 0; c < NUM_COLS; c++) begin
            vals[c] <= '0;
          end
        end
      end
      S_DIV: begin
        ratio <= div_quot;
        col   <= 2'd0;
      end
      S_MUL: begin
        prod <= ratio_s * diff;
      end
      S_ACC: begin
        vals[col] <= sat_val(acc);
        col       <= col + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      distance_echo <= meas_dist;
      in_range      <= res_range;
      value_one     <= vals[0];
      value_two     <= vals[1];
      value_three   <= vals[2];
    end
  end

endmodule
